// ===== rtl/core/gga_pkg.sv =====
// ----------------------------------------------------------------------------
// gga_pkg: shared types and constants of the gga position parser
// character codes, field numbers, output widths and the divide-by-60 constants
// ----------------------------------------------------------------------------
package gga_pkg;

  localparam int MAX_SENTENCE_LEN = 128;
  localparam int FRACTION_DIGITS  = 5;

  localparam int LAT_W     = 25;
  localparam int LON_W     = 28;
  localparam int LAT_MAG_W = 24;
  localparam int LON_MAG_W = 27;
  localparam int DEG_W     = 10;
  localparam int FRAC_W    = 17;
  localparam int NUM_W     = 23;
  localparam int OUT_DATA_W = 56;

  localparam int DEG_SCALE = 100000;
  // floor(n / 60) == (n * DIV60_MULT) >> DIV60_SHIFT for every n below 2**23
  localparam logic [23:0] DIV60_MULT  = 24'd8947849;
  localparam int          DIV60_SHIFT = 29;
  localparam int          PROD_W      = NUM_W + 24;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_N      = 8'h4e;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;

  localparam logic [2:0] FLD_TIME = 3'd1;
  localparam logic [2:0] FLD_LAT  = 3'd2;
  localparam logic [2:0] FLD_NS   = 3'd3;
  localparam logic [2:0] FLD_LON  = 3'd4;
  localparam logic [2:0] FLD_EW   = 3'd5;
  localparam logic [2:0] FLD_LAST = 3'd6;

  localparam logic [7:0] HDR_COMMA_POS = 8'd7;
  localparam logic [7:0] HDR_LAST_POS  = 8'd6;
  localparam logic [2:0] HDR_ALT_POS   = 3'd2;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_FIELDS = 4'b0100,
    PH_TAIL   = 4'b1000
  } phase_t;

  // expected header character after the dollar sign, position 1..5
  function automatic logic [7:0] header_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd1:    ch = CH_G;
      3'd2:    ch = CH_P;
      3'd3:    ch = CH_G;
      3'd4:    ch = CH_G;
      3'd5:    ch = CH_A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // weight of a fraction digit so the fraction reads as five digits
  function automatic logic [13:0] frac_weight(input logic [2:0] cnt);
    logic [13:0] w;
    case (cnt)
      3'd0:    w = 14'd10000;
      3'd1:    w = 14'd1000;
      3'd2:    w = 14'd100;
      3'd3:    w = 14'd10;
      3'd4:    w = 14'd1;
      default: w = 14'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/nmea_gga_position_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_position_parser
// parses gga sentences byte by byte and returns latitude and longitude in
// signed units of 1e-5 degrees
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser/tlast
//  in_     | in  | [7:0] rx_byte                           | -
//  out_    | out | [24:0] latitude_e5, [52:25] longitude_e5| -
//
// one byte per cycle while no held result stalls; a byte is registered on
// accept and parsed from there; a result is registered as its '\n' is parsed.
// a coordinate is scaled (minutes to 1e-5 degrees, divide by 60 through a
// reciprocal multiply) in the cycle after its field closes.
// reset clears the parser control state at once, no clearing pass.
// a held result stalls only the byte in the input register; a new byte is
// taken whenever the result register is empty or being read.
module nmea_gga_position_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gga_pkg::OUT_DATA_W-1:0] out_tdata  // [24:0] latitude_e5,
                                                    // [52:25] longitude_e5
);

  // input register
  logic [7:0] byte_r;
  logic       byte_vld_r, byte_vld_nxt;
  logic       in_acc, proc_go;

  // parser state
  gga_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  byte_cnt_r, byte_cnt_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [2:0]  fld_num_r, fld_num_nxt;
  logic [gga_pkg::DEG_W-1:0] deg_hi_r, deg_hi_nxt;
  logic [3:0]  min_tens_r, min_tens_nxt;
  logic [3:0]  min_ones_r, min_ones_nxt;
  logic        int_ovf_r, int_ovf_nxt;
  logic [gga_pkg::FRAC_W-1:0] frac_pad_r, frac_pad_nxt;
  logic [2:0]  frac_cnt_r, frac_cnt_nxt;
  logic        point_seen_r, point_seen_nxt;
  logic        field_bad_r, field_bad_nxt;
  logic        field_seen_r, field_seen_nxt;
  logic        south_r, south_nxt;
  logic        west_r, west_nxt;
  logic [3:0]  fvalid_r, fvalid_nxt;

  // coordinate scaling stage
  logic        cv_vld_r, cv_vld_nxt;
  logic        cv_lon_r, cv_lon_nxt;
  logic [gga_pkg::DEG_W-1:0] cv_deg_r, cv_deg_nxt;
  logic [gga_pkg::NUM_W-1:0] cv_num_r, cv_num_nxt;
  logic [gga_pkg::PROD_W-1:0] cv_prod;
  logic [gga_pkg::LON_MAG_W-1:0] cv_mag;
  logic [gga_pkg::LAT_MAG_W-1:0] lat_mag_r;
  logic [gga_pkg::LON_MAG_W-1:0] lon_mag_r;

  // result register
  logic        out_vld_r, out_vld_nxt;
  logic [gga_pkg::LAT_W-1:0] out_lat_r, out_lat_nxt;
  logic [gga_pkg::LON_W-1:0] out_lon_r, out_lon_nxt;

  // byte decode and field close terms
  logic [7:0]  ch;
  logic [7:0]  cnt_inc;
  logic [2:0]  hdr_pos;
  logic        is_digit;
  logic [3:0]  digit;
  logic [13:0] hi_shift;
  logic [6:0]  mins;
  logic [gga_pkg::NUM_W-1:0] num;
  logic        coord_ok, letter_ok;
  logic [3:0]  close_bits;
  logic        emit;

  assign in_acc    = in_tvalid && in_tready;
  assign proc_go   = byte_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !byte_vld_r || proc_go;

  assign ch       = byte_r;
  assign cnt_inc  = byte_cnt_r + 8'd1;
  assign hdr_pos  = 3'(cnt_inc - 8'd1);
  assign is_digit = (ch >= gga_pkg::CH_ZERO) && (ch <= gga_pkg::CH_NINE);
  assign digit    = 4'(ch - gga_pkg::CH_ZERO);
  assign hi_shift = 14'(deg_hi_r) * 14'd10 + 14'(min_tens_r);

  assign mins = 7'(min_tens_r) * 7'd10 + 7'(min_ones_r);
  assign num  = NUM_W'(mins) * NUM_W'(gga_pkg::DEG_SCALE) + NUM_W'(frac_pad_r);

  localparam int NUM_W = gga_pkg::NUM_W;

  assign coord_ok  = field_seen_r && !field_bad_r && !int_ovf_r && (min_tens_r < 4'd6);
  assign letter_ok = field_seen_r && !field_bad_r;

  always_comb begin
    close_bits    = 4'b0000;
    close_bits[0] = (fld_num_r == gga_pkg::FLD_LAT) && coord_ok &&
                    (deg_hi_r <= gga_pkg::DEG_W'(99));
    close_bits[1] = (fld_num_r == gga_pkg::FLD_NS) && letter_ok;
    close_bits[2] = (fld_num_r == gga_pkg::FLD_LON) && coord_ok;
    close_bits[3] = (fld_num_r == gga_pkg::FLD_EW) && letter_ok;
  end

  always_comb begin
    phase_nxt      = phase_r;
    byte_cnt_nxt   = byte_cnt_r;
    hdr_ok_nxt     = hdr_ok_r;
    fld_num_nxt    = fld_num_r;
    deg_hi_nxt     = deg_hi_r;
    min_tens_nxt   = min_tens_r;
    min_ones_nxt   = min_ones_r;
    int_ovf_nxt    = int_ovf_r;
    frac_pad_nxt   = frac_pad_r;
    frac_cnt_nxt   = frac_cnt_r;
    point_seen_nxt = point_seen_r;
    field_bad_nxt  = field_bad_r;
    field_seen_nxt = field_seen_r;
    south_nxt      = south_r;
    west_nxt       = west_r;
    fvalid_nxt     = fvalid_r;
    cv_vld_nxt     = 1'b0;
    cv_lon_nxt     = cv_lon_r;
    cv_deg_nxt     = cv_deg_r;
    cv_num_nxt     = cv_num_r;
    emit           = 1'b0;

    if (proc_go) begin
      if (ch == gga_pkg::CH_DOLLAR) begin
        phase_nxt      = gga_pkg::PH_HEADER;
        byte_cnt_nxt   = 8'd1;
        hdr_ok_nxt     = 1'b1;
        fld_num_nxt    = 3'd0;
        fvalid_nxt     = 4'b0000;
        south_nxt      = 1'b0;
        west_nxt       = 1'b0;
        deg_hi_nxt     = '0;
        min_tens_nxt   = 4'd0;
        min_ones_nxt   = 4'd0;
        int_ovf_nxt    = 1'b0;
        frac_pad_nxt   = '0;
        frac_cnt_nxt   = 3'd0;
        point_seen_nxt = 1'b0;
        field_bad_nxt  = 1'b0;
        field_seen_nxt = 1'b0;
      end else if (phase_r != gga_pkg::PH_IDLE) begin
        if (byte_cnt_r >= 8'(gga_pkg::MAX_SENTENCE_LEN)) begin
          // too long, drop silently
          phase_nxt = gga_pkg::PH_IDLE;
        end else begin
          byte_cnt_nxt = cnt_inc;
          case (phase_r)
            gga_pkg::PH_HEADER: begin
              if (ch == gga_pkg::CH_COMMA) begin
                if (hdr_ok_r && cnt_inc == gga_pkg::HDR_COMMA_POS) begin
                  phase_nxt      = gga_pkg::PH_FIELDS;
                  fld_num_nxt    = gga_pkg::FLD_TIME;
                  deg_hi_nxt     = '0;
                  min_tens_nxt   = 4'd0;
                  min_ones_nxt   = 4'd0;
                  int_ovf_nxt    = 1'b0;
                  frac_pad_nxt   = '0;
                  frac_cnt_nxt   = 3'd0;
                  point_seen_nxt = 1'b0;
                  field_bad_nxt  = 1'b0;
                  field_seen_nxt = 1'b0;
                end else begin
                  phase_nxt = gga_pkg::PH_IDLE;
                end
              end else if (ch == gga_pkg::CH_LF || cnt_inc > gga_pkg::HDR_LAST_POS) begin
                phase_nxt = gga_pkg::PH_IDLE;
              end else if (!(ch == gga_pkg::header_char(hdr_pos) ||
                             (hdr_pos == gga_pkg::HDR_ALT_POS && ch == gga_pkg::CH_N))) begin
                hdr_ok_nxt = 1'b0;
              end
            end
            gga_pkg::PH_FIELDS, gga_pkg::PH_TAIL: begin
              if (ch == gga_pkg::CH_LF) begin
                // a newline still closes an open field before the check
                if (phase_r == gga_pkg::PH_FIELDS) begin
                  emit = hdr_ok_r && ((fvalid_r | close_bits) == 4'hf);
                end else begin
                  emit = hdr_ok_r && (fvalid_r == 4'hf);
                end
                phase_nxt = gga_pkg::PH_IDLE;
                if (phase_r == gga_pkg::PH_FIELDS) begin
                  fvalid_nxt = fvalid_r | close_bits;
                end
              end else if (phase_r == gga_pkg::PH_FIELDS) begin
                if (ch == gga_pkg::CH_COMMA || ch == gga_pkg::CH_STAR ||
                    ch == gga_pkg::CH_CR) begin
                  fvalid_nxt = fvalid_r | close_bits;
                  if (close_bits[0] || close_bits[2]) begin
                    cv_vld_nxt = 1'b1;
                    cv_lon_nxt = close_bits[2];
                    cv_deg_nxt = deg_hi_r;
                    cv_num_nxt = num;
                  end
                  if (ch == gga_pkg::CH_COMMA) begin
                    if (fld_num_r < gga_pkg::FLD_LAST) begin
                      fld_num_nxt = fld_num_r + 3'd1;
                    end
                    deg_hi_nxt     = '0;
                    min_tens_nxt   = 4'd0;
                    min_ones_nxt   = 4'd0;
                    int_ovf_nxt    = 1'b0;
                    frac_pad_nxt   = '0;
                    frac_cnt_nxt   = 3'd0;
                    point_seen_nxt = 1'b0;
                    field_bad_nxt  = 1'b0;
                    field_seen_nxt = 1'b0;
                  end else begin
                    phase_nxt = gga_pkg::PH_TAIL;
                  end
                end else if (fld_num_r == gga_pkg::FLD_LAT || fld_num_r == gga_pkg::FLD_LON) begin
                  if (is_digit) begin
                    field_seen_nxt = 1'b1;
                    if (!point_seen_r) begin
                      // integer part kept as degrees plus two minute digits
                      if (!int_ovf_r) begin
                        if (hi_shift > 14'd999) begin
                          int_ovf_nxt = 1'b1;
                        end else begin
                          deg_hi_nxt   = gga_pkg::DEG_W'(hi_shift);
                          min_tens_nxt = min_ones_r;
                          min_ones_nxt = digit;
                        end
                      end
                    end else if (frac_cnt_r < 3'(gga_pkg::FRACTION_DIGITS)) begin
                      frac_pad_nxt = frac_pad_r +
                                     FRAC_W'(digit) * FRAC_W'(gga_pkg::frac_weight(frac_cnt_r));
                      frac_cnt_nxt = frac_cnt_r + 3'd1;
                    end
                  end else if (ch == gga_pkg::CH_DOT && !point_seen_r) begin
                    point_seen_nxt = 1'b1;
                  end else begin
                    field_bad_nxt = 1'b1;
                  end
                end else if (fld_num_r == gga_pkg::FLD_NS || fld_num_r == gga_pkg::FLD_EW) begin
                  if (field_seen_r) begin
                    field_bad_nxt = 1'b1;
                  end else begin
                    field_seen_nxt = 1'b1;
                    if (fld_num_r == gga_pkg::FLD_NS) begin
                      if (ch == gga_pkg::CH_S) begin
                        south_nxt = 1'b1;
                      end else if (ch == gga_pkg::CH_N) begin
                        south_nxt = 1'b0;
                      end else begin
                        field_bad_nxt = 1'b1;
                      end
                    end else begin
                      if (ch == gga_pkg::CH_W) begin
                        west_nxt = 1'b1;
                      end else if (ch == gga_pkg::CH_E) begin
                        west_nxt = 1'b0;
                      end else begin
                        field_bad_nxt = 1'b1;
                      end
                    end
                  end
                end
              end
            end
            default: begin
              phase_nxt = gga_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  localparam int FRAC_W = gga_pkg::FRAC_W;

  // minutes to 1e-5 degrees, then whole degrees added
  assign cv_prod = PROD_W'(cv_num_r) * PROD_W'(gga_pkg::DIV60_MULT);
  assign cv_mag  = LON_MAG_W'(cv_deg_r) * LON_MAG_W'(gga_pkg::DEG_SCALE) +
                   LON_MAG_W'(cv_prod >> gga_pkg::DIV60_SHIFT);

  localparam int PROD_W    = gga_pkg::PROD_W;
  localparam int LON_MAG_W = gga_pkg::LON_MAG_W;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_lat_nxt = out_lat_r;
    out_lon_nxt = out_lon_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (emit) begin
      out_vld_nxt = 1'b1;
      out_lat_nxt = south_r ? (gga_pkg::LAT_W'(0) - gga_pkg::LAT_W'(lat_mag_r))
                            : gga_pkg::LAT_W'(lat_mag_r);
      out_lon_nxt = west_r  ? (gga_pkg::LON_W'(0) - gga_pkg::LON_W'(lon_mag_r))
                            : gga_pkg::LON_W'(lon_mag_r);
    end
  end

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_acc) begin
      byte_vld_nxt = 1'b1;
    end else if (proc_go) begin
      byte_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r   <= 1'b0;
      phase_r      <= gga_pkg::PH_IDLE;
      byte_cnt_r   <= 8'd0;
      hdr_ok_r     <= 1'b0;
      fld_num_r    <= 3'd0;
      int_ovf_r    <= 1'b0;
      frac_cnt_r   <= 3'd0;
      point_seen_r <= 1'b0;
      field_bad_r  <= 1'b0;
      field_seen_r <= 1'b0;
      south_r      <= 1'b0;
      west_r       <= 1'b0;
      fvalid_r     <= 4'b0000;
      cv_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      byte_vld_r   <= byte_vld_nxt;
      phase_r      <= phase_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      hdr_ok_r     <= hdr_ok_nxt;
      fld_num_r    <= fld_num_nxt;
      int_ovf_r    <= int_ovf_nxt;
      frac_cnt_r   <= frac_cnt_nxt;
      point_seen_r <= point_seen_nxt;
      field_bad_r  <= field_bad_nxt;
      field_seen_r <= field_seen_nxt;
      south_r      <= south_nxt;
      west_r       <= west_nxt;
      fvalid_r     <= fvalid_nxt;
      cv_vld_r     <= cv_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
    end
    deg_hi_r   <= deg_hi_nxt;
    min_tens_r <= min_tens_nxt;
    min_ones_r <= min_ones_nxt;
    frac_pad_r <= frac_pad_nxt;
    cv_lon_r   <= cv_lon_nxt;
    cv_deg_r   <= cv_deg_nxt;
    cv_num_r   <= cv_num_nxt;
    out_lat_r  <= out_lat_nxt;
    out_lon_r  <= out_lon_nxt;
    if (cv_vld_r) begin
      if (cv_lon_r) begin
        lon_mag_r <= cv_mag;
      end else begin
        lat_mag_r <= gga_pkg::LAT_MAG_W'(cv_mag);
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_lon_r, out_lat_r};

endmodule

// ===== rtl/core/gga_checker.sv =====
// ----------------------------------------------------------------------------
// gga_checker: port-level checks for the gga position parser
// watches only the stream ports and is bound to the top level
// ----------------------------------------------------------------------------
module gga_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [7:0]                    in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [gga_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a result held by the sink keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty result register never blocks a new byte
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  // a fresh result follows an accepted newline request
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2) &&
                          ($past(in_tdata, 2) == gga_pkg::CH_LF))
    else $error("result without a preceding newline");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[24:0]) <= 25'sd9999999) &&
                   ($signed(out_tdata[24:0]) >= -25'sd9999999))
    else $error("latitude out of range");

  a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[52:25]) <= 28'sd99999999) &&
                   ($signed(out_tdata[52:25]) >= -28'sd99999999) &&
                   (out_tdata[55:53] == 3'b000))
    else $error("longitude out of range or padding set");

endmodule

bind nmea_gga_position_parser gga_checker u_gga_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb_nmea_gga_position_parser.sv =====
// ----------------------------------------------------------------------------
// tb_nmea_gga_position_parser: self-checking bench of the gga position parser
// feeds nmea byte streams (directed sentences, then random well-formed and
// broken sentences with noise), predicts every untyped fix in a behavioural model
// and compares each result request field by field against the oldest fix
// ----------------------------------------------------------------------------
module tb_nmea_gga_position_parser;
  import gga_pkg::*;

  localparam int          ITEM_TARGET      = 1850;
  localparam int          MIN_RANDOM_FIXES = 48;
  localparam int          CYCLE_LIMIT      = 400000;
  localparam int          TAIL_CYCLES      = 16;
  localparam int unsigned LAT_INT_CAP      = 9999;
  localparam int unsigned LON_INT_CAP      = 99999;
  localparam int unsigned DIGIT_SAT        = 100000;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } fix_t;

  typedef struct {
    string text;
    int    pad;       // zeros stuffed into the time field
    bit    typed;     // fix below is written out, predictor not used
    bit    has_fix;
    int    lat;
    int    lon;
  } row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = 8'h00;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic signed [LAT_W-1:0] seen_lat;
  logic signed [LON_W-1:0] seen_lon;
  assign seen_lat = out_tdata[LAT_W-1:0];
  assign seen_lon = out_tdata[LAT_W+LON_W-1:LAT_W];

  nmea_gga_position_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  fix_t         fixes_due[$];
  logic [7:0]   line_buf[$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  int           bytes_sent  = 0;
  int           fixes_made  = 0;
  int           snd_idle_pct = 19;
  int           rcv_idle_pct = 85;

  // parser shadow state
  phase_t       ph;
  int unsigned  cnt;
  bit           hdr_ok;
  int unsigned  fld;
  int unsigned  ival, fval, fcnt;
  bit           pt, bad, seen;
  int unsigned  lat_mag, lon_mag;
  bit           south, west;
  bit [3:0]     valid;
  logic [7:0]   gga_hdr [1:5] = '{CH_G, CH_P, CH_G, CH_G, CH_A};

  row_t dir_rows [23] = '{
    '{"$GPGGA,123519,0000.00000,N,00000.00000,E*47\r\n", 0, 1, 1, 0, 0},
    '{"$GNGGA,,9959.99999,S,99959.99999,W\n", 0, 1, 1, -9999999, -99999999},
    '{"$GPGGA,,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n",
      0, 0, 0, 0, 0},
    '{"$GPGGA,,4807.038,S,01131.000,W\n", 0, 0, 0, 0, 0},
    '{"$GPGGA,,4860.000,N,01131.000,E\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,48070.000,N,01131.000,E\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,4807.038,X,01131.000,E\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,4807.038,,01131.000,E\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,4807.0a8,N,01131.000,E\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,4807.038,N,01131.000\n", 0, 1, 0, 0, 0},
    '{"$GPGLL,4807.038,N,01131.000,E\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,4807.038,N$GNGGA,,12.3456789,N,1.5,W\n", 0, 0, 0, 0, 0},
    '{"$GPGGA,,.5,N,5.,E\n", 0, 0, 0, 0, 0},
    '{"$GPGGA,,.,N,1,E\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,4807.038,N,01131.000,E\r\n", 0, 0, 0, 0, 0},
    '{"$GPGGA\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,1.2.3,N,1,E\n", 0, 1, 0, 0, 0},
    '{"$GPGGA,,1,NN,1,E\n", 0, 1, 0, 0, 0},
    '{"$GPGG,,1,N,1,E\n", 0, 1, 0, 0, 0},
    '{"$GNGGB,,1,N,1,E\n", 0, 1, 0, 0, 0},
    '{"xyz\n,,$$GPGGA,,0,N,0,E\n", 0, 1, 1, 0, 0},
    // 128 bytes from the dollar sign still fits, one more drops the sentence
    '{"$GPGGA,,4807.038,N,01131.000,E\n", 97, 0, 0, 0, 0},
    '{"$GPGGA,,4807.038,N,01131.000,E\n", 98, 1, 0, 0, 0}
  };

  function automatic void clear_field_acc();
    ival = 0;
    fval = 0;
    fcnt = 0;
    pt   = 1'b0;
    bad  = 1'b0;
    seen = 1'b0;
  endfunction

  function automatic bit scale_coord(input int unsigned cap, output int unsigned mag);
    int unsigned mins, w;
    mag = 0;
    if (bad || !seen || ival > cap) return 1'b0;
    mins = ival % 100;
    if (mins >= 60) return 1'b0;
    w = 1;
    repeat (5 - fcnt) w = w * 10;
    mag = (ival / 100) * DEG_SCALE + (mins * DEG_SCALE + fval * w) / 60;
    return 1'b1;
  endfunction

  function automatic void close_field_acc();
    int unsigned m;
    if (fld == FLD_LAT) begin
      if (scale_coord(LAT_INT_CAP, m)) begin
        lat_mag  = m;
        valid[0] = 1'b1;
      end
    end else if (fld == FLD_LON) begin
      if (scale_coord(LON_INT_CAP, m)) begin
        lon_mag  = m;
        valid[2] = 1'b1;
      end
    end else if (fld == FLD_NS) begin
      if (seen && !bad) valid[1] = 1'b1;
    end else if (fld == FLD_EW) begin
      if (seen && !bad) valid[3] = 1'b1;
    end
  endfunction

  function automatic void coord_char(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      seen = 1'b1;
      if (!pt) begin
        if (ival < DIGIT_SAT) begin
          ival = ival * 10 + (c - CH_ZERO);
          if (ival > DIGIT_SAT) ival = DIGIT_SAT;
        end
      end else if (fcnt < FRACTION_DIGITS) begin
        fval = fval * 10 + (c - CH_ZERO);
        fcnt++;
      end
    end else if (c == CH_DOT && !pt) begin
      pt = 1'b1;
    end else begin
      bad = 1'b1;
    end
  endfunction

  // returns the new hemisphere flag
  function automatic bit letter_char(input logic [7:0] c, input logic [7:0] pos_ch,
                                     input logic [7:0] neg_ch, input bit flag);
    if (seen) begin
      bad = 1'b1;
      return flag;
    end
    seen = 1'b1;
    if (c == neg_ch) return 1'b1;
    if (c == pos_ch) return 1'b0;
    bad = 1'b1;
    return flag;
  endfunction

  function automatic void track_gga_byte(input logic [7:0] c, output bit got,
                                         output fix_t f);
    got = 1'b0;
    f   = '0;
    if (c == CH_DOLLAR) begin
      ph     = PH_HEADER;
      cnt    = 1;
      hdr_ok = 1'b1;
      fld    = 0;
      valid  = '0;
      south  = 1'b0;
      west   = 1'b0;
      clear_field_acc();
      return;
    end
    if (ph == PH_IDLE) return;
    if (cnt >= MAX_SENTENCE_LEN || cnt >= 255) begin
      ph = PH_IDLE;
      return;
    end
    cnt++;
    if (ph == PH_HEADER) begin
      if (c == CH_COMMA) begin
        if (hdr_ok && cnt == HDR_COMMA_POS) begin
          ph  = PH_FIELDS;
          fld = FLD_TIME;
          clear_field_acc();
        end else begin
          ph = PH_IDLE;
        end
      end else if (c == CH_LF || cnt > HDR_LAST_POS) begin
        ph = PH_IDLE;
      end else if (!(c == gga_hdr[cnt-1] || (cnt - 1 == HDR_ALT_POS && c == CH_N))) begin
        hdr_ok = 1'b0;
      end
      return;
    end
    if (c == CH_LF) begin
      if (ph == PH_FIELDS) close_field_acc();
      if (hdr_ok && valid == 4'hf) begin
        got   = 1'b1;
        f.lat = LAT_W'(south ? 0 - lat_mag : lat_mag);
        f.lon = LON_W'(west ? 0 - lon_mag : lon_mag);
      end
      ph = PH_IDLE;
      return;
    end
    if (ph == PH_TAIL) return;
    if (c == CH_COMMA) begin
      close_field_acc();
      if (fld < FLD_LAST) fld++;
      clear_field_acc();
    end else if (c == CH_STAR || c == CH_CR) begin
      close_field_acc();
      ph = PH_TAIL;
    end else if (fld == FLD_LAT || fld == FLD_LON) begin
      coord_char(c);
    end else if (fld == FLD_NS) begin
      south = letter_char(c, CH_N, CH_S, south);
    end else if (fld == FLD_EW) begin
      west = letter_char(c, CH_E, CH_W, west);
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit keep);
    bit   got;
    fix_t f;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    track_gga_byte(b, got, f);
    if (got && keep) begin
      fixes_due.push_back(f);
      fixes_made++;
    end
    bytes_sent++;
  endtask

  task automatic drain_fixes();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fixes_due.size() != 0) @(posedge clk);
  endtask

  function automatic void put_text(input string s);
    foreach (s[i]) line_buf.push_back(s[i]);
  endfunction

  function automatic void put_digits(input int n);
    repeat (n) line_buf.push_back(CH_ZERO + $urandom_range(9));
  endfunction

  function automatic void put_coord(input int deg_max, input int over);
    int r, m;
    r = $urandom_range(99);
    if (r < 4) return;
    if (r < 9) begin
      put_digits($urandom_range(over + 3, over));
    end else begin
      put_digits($urandom_range(deg_max));
      m = (r < 17) ? $urandom_range(99, 60) : $urandom_range(59);
      if ($urandom_range(9) != 0) line_buf.push_back(CH_ZERO + m / 10);
      line_buf.push_back(CH_ZERO + m % 10);
    end
    if ($urandom_range(99) < 80) begin
      line_buf.push_back(CH_DOT);
      put_digits($urandom_range(7));
    end
    if ($urandom_range(99) < 4) line_buf.push_back($urandom_range(126, 32));
  endfunction

  function automatic void put_letter(input logic [7:0] pos_ch, input logic [7:0] neg_ch);
    int r;
    r = $urandom_range(99);
    if (r < 45)      line_buf.push_back(pos_ch);
    else if (r < 90) line_buf.push_back(neg_ch);
    else if (r < 93) ;
    else if (r < 96) begin
      line_buf.push_back(neg_ch);
      line_buf.push_back(pos_ch);
    end else line_buf.push_back($urandom_range(CH_W + 3, CH_A));
  endfunction

  function automatic void put_checksum();
    string hex;
    hex = "0123456789ABCDEF";
    line_buf.push_back(CH_STAR);
    line_buf.push_back(hex[$urandom_range(15)]);
    line_buf.push_back(hex[$urandom_range(15)]);
    put_text("\r\n");
  endfunction

  // mostly well-formed gga sentences with random content, some broken
  function automatic void build_sentence();
    int r, cut, target;
    line_buf.delete();
    if ($urandom_range(99) < 6)
      repeat ($urandom_range(5, 1)) line_buf.push_back($urandom_range(255));
    put_text($urandom_range(1) ? "$GPGGA" : "$GNGGA");
    r = $urandom_range(99);
    if (r < 5)      line_buf[line_buf.size() - $urandom_range(5, 1)] = $urandom_range(CH_W + 3, CH_A);
    else if (r < 7) void'(line_buf.pop_back());
    line_buf.push_back(CH_COMMA);
    put_digits($urandom_range(6));
    if ($urandom_range(3) == 0) put_text(".00");
    line_buf.push_back(CH_COMMA);
    put_coord(2, 5);
    line_buf.push_back(CH_COMMA);
    put_letter(CH_N, CH_S);
    line_buf.push_back(CH_COMMA);
    put_coord(3, 6);
    line_buf.push_back(CH_COMMA);
    put_letter(CH_E, CH_W);
    r = $urandom_range(99);
    if (r < 35)      line_buf.push_back(CH_LF);
    else if (r < 55) put_text("\r\n");
    else if (r < 75) put_checksum();
    else begin
      put_text(",1,08,0.9,545.4,M,46.9,M,,");
      put_checksum();
    end
    r = $urandom_range(99);
    if (r < 5) begin
      cut = $urandom_range(line_buf.size() - 1, 1);
      while (line_buf.size() > cut) void'(line_buf.pop_back());
    end else if (r < 9) begin
      // stretch the time field to straddle the length limit
      target = $urandom_range(MAX_SENTENCE_LEN + 4, MAX_SENTENCE_LEN - 4);
      while (line_buf.size() < target) line_buf.insert(7, CH_ZERO);
    end
  endfunction

  // result side: check each accepted request, then choose the next ready
  always @(posedge clk) begin
    fix_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (fixes_due.size() == 0) begin
        $error("unexpected result: latitude_e5 %0d longitude_e5 %0d", seen_lat, seen_lon);
        mismatches++;
      end else begin
        want = fixes_due.pop_front();
        if (seen_lat !== want.lat) begin
          $error("latitude_e5: expected %0d, got %0d", want.lat, seen_lat);
          mismatches++;
        end
        if (seen_lon !== want.lon) begin
          $error("longitude_e5: expected %0d, got %0d", want.lon, seen_lon);
          mismatches++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int   first;
    fix_t f;
    ph      = PH_IDLE;
    cnt     = 0;
    hdr_ok  = 1'b0;
    fld     = 0;
    lat_mag = 0;
    lon_mag = 0;
    south   = 1'b0;
    west    = 1'b0;
    valid   = '0;
    clear_field_acc();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // byte extremes outside any sentence
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b1);
    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        push_byte(dir_rows[r].text[i], !dir_rows[r].typed);
        if (i == 6) repeat (dir_rows[r].pad) push_byte(CH_ZERO, !dir_rows[r].typed);
      end
      if (dir_rows[r].typed && dir_rows[r].has_fix) begin
        f.lat = LAT_W'(dir_rows[r].lat);
        f.lon = LON_W'(dir_rows[r].lon);
        fixes_due.push_back(f);
      end
    end
    drain_fixes();

    first      = bytes_sent;
    fixes_made = 0;
    while (bytes_sent - first < ITEM_TARGET || fixes_made < MIN_RANDOM_FIXES) begin
      if (snd_idle_pct == 19 && bytes_sent - first >= ITEM_TARGET / 3) begin
        drain_fixes();
        snd_idle_pct = 85;
        rcv_idle_pct = 19;
      end else if (snd_idle_pct == 85 && bytes_sent - first >= 2 * ITEM_TARGET / 3) begin
        drain_fixes();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      build_sentence();
      foreach (line_buf[i]) push_byte(line_buf[i], 1'b1);
    end

    drain_fixes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
